@@ src/vfpq_pkg.sv @@
// ----------------------------------------------------------------------------
// vfpq_pkg
// Shared types and constants of the video frame presentation queue.
// ----------------------------------------------------------------------------
package vfpq_pkg;

	localparam int DEF_QUEUE_DEPTH = 128;
	localparam int DEF_TIME_BITS   = 32;

	// Stream payload widths
	localparam int IN_DATA_W  = 80;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 72;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	// Operation codes carried in the input tuser
	localparam logic [1:0] FUNC_PUSH  = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LATE_DROP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AHEAD_TOL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CORR    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 3'd5;

	// Register reset values
	localparam logic [7:0]  RST_QUEUE_LIMIT = 8'd90;
	localparam logic [15:0] RST_LATE_DROP   = 16'd120;
	localparam logic [9:0]  RST_AHEAD_TOL   = 10'd5;
	localparam logic [9:0]  RST_DEAD_ZONE   = 10'd8;
	localparam logic [9:0]  RST_MAX_CORR    = 10'd40;
	localparam logic [30:0] RST_DURATION    = 31'd0;

	typedef struct packed {
		logic load;
		logic clear;
		logic bypass;
		logic push;
		logic pop_drop;
		logic show;
		logic corr_sum;
		logic corr_upd;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic over_limit;
		logic late;
		logic due;
		logic err_big;
	} dp_status_t;

endpackage

@@ src/vfpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// vfpq_ctrl
// Sequencer: decodes each request and steps the datapath through it.
// ----------------------------------------------------------------------------
module vfpq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           in_func,
	input  logic                 in_playing,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vfpq_pkg::dp_cmd_t    cmd,
	input  vfpq_pkg::dp_status_t sts
);
	import vfpq_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_BYPASS = 8'b0000_0010,
		ST_PUSH   = 8'b0000_0100,
		ST_RD     = 8'b0000_1000,
		ST_EV     = 8'b0001_0000,
		ST_CORR_A = 8'b0010_0000,
		ST_CORR_B = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					case (in_func)
						FUNC_PUSH: state_nxt = in_playing ? ST_PUSH : ST_BYPASS;
						FUNC_TICK: begin
							if (in_playing) state_nxt = ST_RD;
						end
						FUNC_CLEAR: cmd.clear = 1'b1;
						default: ;
					endcase
				end
			end
			ST_BYPASS: begin
				cmd.bypass = 1'b1;
				state_nxt  = ST_FIN;
			end
			ST_PUSH: begin
				cmd.push  = 1'b1;
				state_nxt = ST_FIN;
			end
			// head entry is read out while in this state
			ST_RD: state_nxt = sts.cnt_zero ? ST_FIN : ST_EV;
			ST_EV: begin
				if (sts.over_limit || sts.late) begin
					cmd.pop_drop = 1'b1;
					state_nxt    = ST_RD;
				end else if (sts.due) begin
					cmd.show  = 1'b1;
					state_nxt = ST_CORR_A;
				end else begin
					state_nxt = ST_FIN;
				end
			end
			ST_CORR_A: begin
				cmd.corr_sum = 1'b1;
				state_nxt    = sts.err_big ? ST_CORR_B : ST_FIN;
			end
			ST_CORR_B: begin
				cmd.corr_upd = 1'b1;
				state_nxt    = ST_FIN;
			end
			ST_FIN: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/vfpq_dp.sv @@
// ----------------------------------------------------------------------------
// vfpq_dp
// Datapath: registers, frame memory, queue pointers, timing compares and
// render clock correction.
// ----------------------------------------------------------------------------
module vfpq_dp #(
	parameter int QUEUE_DEPTH = vfpq_pkg::DEF_QUEUE_DEPTH,
	parameter int TIME_BITS   = vfpq_pkg::DEF_TIME_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vfpq_pkg::dp_cmd_t                   cmd,
	output vfpq_pkg::dp_status_t                sts,
	input  logic                                cfg_valid,
	input  logic [vfpq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vfpq_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [15:0]                         in_tag,
	input  logic signed [31:0]                  in_pts,
	input  logic [30:0]                         in_master,
	output logic                                out_shown,
	output logic [15:0]                         out_tag,
	output logic [30:0]                         out_pos,
	output logic [7:0]                          out_drops,
	output logic signed [10:0]                  out_corr
);
	import vfpq_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = (CW > 8) ? CW : 8;
	localparam int AW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 3;

	// configuration
	logic [7:0]  qlim_q;
	logic [15:0] late_q;
	logic [9:0]  tol_q;
	logic [9:0]  dz_q;
	logic [9:0]  maxc_q;
	logic [30:0] dur_q;

	// queue state
	logic [PW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic signed [10:0] corr_q;

	logic [TIME_BITS-1:0] pts_mem [QUEUE_DEPTH];
	logic [15:0]          tag_mem [QUEUE_DEPTH];
	logic [TIME_BITS-1:0] rd_pts_q;
	logic [15:0]          rd_tag_q;

	// latched request and result
	logic [15:0]        tag_in_q;
	logic signed [31:0] pts_in_q;
	logic [30:0]        master_q;
	logic               res_shown_q;
	logic [15:0]        res_tag_q;
	logic [30:0]        res_pos_q;
	logic [7:0]         res_drops_q;
	logic signed [AW-1:0] err_q;
	logic signed [AW:0]   sum_q;

	// derived
	logic [LW-1:0]        lim_ext, lim_eff, cnt_ext;
	logic                 full;
	logic [PW-1:0]        head_nxt, slot;
	logic [PW:0]          slot_sum;
	logic signed [AW-1:0] hp, pts_a, master_a, corr_a, late_a, tol_a, dz_a, mag;
	logic signed [AW:0]   corr3, sum_nxt, sum_adj, quo, lim_a, corr_clamp;

	function automatic logic [30:0] clamp_pos(input logic signed [AW-1:0] v,
	                                          input logic [30:0] dur);
		logic signed [AW-1:0] dur_a;
		logic [30:0]          r;
		dur_a = signed'(AW'(dur));
		if (v < 0) begin
			r = '0;
		end else if ((dur != '0) && (v > dur_a)) begin
			r = dur;
		end else begin
			r = v[30:0];
		end
		return r;
	endfunction

	// effective limit, clamped to [1, depth]
	assign lim_ext = LW'(qlim_q);
	assign lim_eff = (lim_ext == '0) ? LW'(1) :
	                 (lim_ext > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : lim_ext;
	assign cnt_ext = LW'(count_q);
	assign full    = cnt_ext >= lim_eff;

	assign head_nxt = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign slot_sum = (PW + 1)'(head_q) + (PW + 1)'(count_q);
	assign slot     = (slot_sum >= (PW + 1)'(QUEUE_DEPTH)) ?
	                  PW'(slot_sum - (PW + 1)'(QUEUE_DEPTH)) : PW'(slot_sum);

	assign hp       = AW'(signed'(rd_pts_q));
	assign pts_a    = AW'(pts_in_q);
	assign master_a = signed'(AW'(master_q));
	assign corr_a   = AW'(corr_q);
	assign late_a   = signed'(AW'(late_q));
	assign tol_a    = signed'(AW'(tol_q));
	assign dz_a     = signed'(AW'(dz_q));

	assign sts.cnt_zero   = (count_q == '0);
	assign sts.over_limit = cnt_ext > lim_eff;
	assign sts.late       = ((hp + late_a) < master_a) && (count_q > CW'(1));
	assign sts.due        = hp <= (master_a + corr_a + tol_a);

	assign mag         = err_q[AW-1] ? -err_q : err_q;
	assign sts.err_big = mag > dz_a;

	// blend (3c + e) / 4, truncated toward zero, then clamp
	assign corr3      = (AW + 1)'(corr_q);
	assign sum_nxt    = (corr3 <<< 1) + corr3 + (AW + 1)'(err_q);
	assign sum_adj    = sum_q[AW] ? sum_q + signed'((AW + 1)'(3)) : sum_q;
	assign quo        = sum_adj >>> 2;
	assign lim_a      = signed'((AW + 1)'(maxc_q));
	assign corr_clamp = (quo > lim_a) ? lim_a : (quo < -lim_a) ? -lim_a : quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlim_q <= RST_QUEUE_LIMIT;
			late_q <= RST_LATE_DROP;
			tol_q  <= RST_AHEAD_TOL;
			dz_q   <= RST_DEAD_ZONE;
			maxc_q <= RST_MAX_CORR;
			dur_q  <= RST_DURATION;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_QUEUE_LIMIT: qlim_q <= cfg_data[7:0];
				CFG_LATE_DROP:   late_q <= cfg_data[15:0];
				CFG_AHEAD_TOL:   tol_q  <= cfg_data[9:0];
				CFG_DEAD_ZONE:   dz_q   <= cfg_data[9:0];
				CFG_MAX_CORR:    maxc_q <= cfg_data[9:0];
				CFG_DURATION:    dur_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			corr_q  <= '0;
		end else begin
			if (cmd.clear) begin
				head_q  <= '0;
				count_q <= '0;
			end else if (cmd.push) begin
				// full: drop the oldest, count stays
				if (full) begin
					head_q <= head_nxt;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end else if (cmd.pop_drop || cmd.show) begin
				head_q  <= head_nxt;
				count_q <= count_q - 1'b1;
			end
			if (cmd.clear) begin
				corr_q <= '0;
			end else if (cmd.corr_upd) begin
				corr_q <= 11'(corr_clamp);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			pts_mem[slot] <= TIME_BITS'(pts_in_q);
			tag_mem[slot] <= tag_in_q;
		end
		rd_pts_q <= pts_mem[head_q];
		rd_tag_q <= tag_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_in_q    <= in_tag;
			pts_in_q    <= in_pts;
			master_q    <= in_master;
			res_shown_q <= 1'b0;
			res_tag_q   <= '0;
			res_pos_q   <= '0;
			res_drops_q <= '0;
		end
		if (cmd.bypass) begin
			res_shown_q <= 1'b1;
			res_tag_q   <= tag_in_q;
			res_pos_q   <= clamp_pos(pts_a, dur_q);
		end
		if (cmd.push && full) begin
			res_drops_q <= 8'd1;
		end
		if (cmd.pop_drop && (res_drops_q != 8'hFF)) begin
			res_drops_q <= res_drops_q + 1'b1;
		end
		if (cmd.show) begin
			res_shown_q <= 1'b1;
			res_tag_q   <= rd_tag_q;
			res_pos_q   <= clamp_pos(hp, dur_q);
			err_q       <= master_a - hp;
		end
		if (cmd.corr_sum) begin
			sum_q <= sum_nxt;
		end
		if (cmd.emit) begin
			out_shown <= res_shown_q;
			out_tag   <= res_tag_q;
			out_pos   <= res_pos_q;
			out_drops <= res_drops_q;
			out_corr  <= corr_q;
		end
	end

endmodule

@@ src/video_frame_presentation_queue_core.sv @@
// ----------------------------------------------------------------------------
// video_frame_presentation_queue_core
// Frame presentation queue: schedules decoded frames against a master clock.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel, the operation in tuser (push, tick,
// clear). A push while paused is shown at once; while playing it is queued,
// dropping the oldest frame when the queue is at its limit. A tick while
// playing drops late or over-limit head frames and shows the head when it is
// due, updating the render clock correction. Push and playing tick each return
// one result on m_axis; paused ticks, clears and unused codes return none.
// Registers are written on the cfg channel (always ready); the user must write
// them only while idle, the block does not enforce it. One request is in work
// at a time. A push passes a queue or bypass state, then a finish state. A tick
// reads and evaluates the head, again per head frame dropped (each pop rereads
// the frame memory through its registered port), then updates the correction.
// The result sits in an output register; a new request is taken while it
// waits, and the sequencer only stalls when a second result is ready before
// the first is taken. Reset empties the queue, zeroes the correction and
// loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module video_frame_presentation_queue_core #(
	parameter int QUEUE_DEPTH = vfpq_pkg::DEF_QUEUE_DEPTH,
	parameter int TIME_BITS   = vfpq_pkg::DEF_TIME_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// playing[0], frame_tag[16:1], pts_ms[48:17], master_clock_ms[79:49]
	input  logic [vfpq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// func[1:0]
	input  logic [vfpq_pkg::IN_USER_W-1:0]    s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// shown[0], shown_tag[16:1], position_ms[47:17], dropped_count[55:48],
	// correction_ms[66:56], zero[71:67]
	output logic [vfpq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vfpq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vfpq_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import vfpq_pkg::*;

	dp_cmd_t            cmd;
	dp_status_t         sts;
	logic               out_shown;
	logic [15:0]        out_tag;
	logic [30:0]        out_pos;
	logic [7:0]         out_drops;
	logic signed [10:0] out_corr;

	assign cfg_ready = 1'b1;

	vfpq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_func    (s_axis_tuser),
		.in_playing (s_axis_tdata[0]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.cmd        (cmd),
		.sts        (sts)
	);

	vfpq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_tag    (s_axis_tdata[16:1]),
		.in_pts    (signed'(s_axis_tdata[48:17])),
		.in_master (s_axis_tdata[79:49]),
		.out_shown (out_shown),
		.out_tag   (out_tag),
		.out_pos   (out_pos),
		.out_drops (out_drops),
		.out_corr  (out_corr)
	);

	assign m_axis_tdata = {5'b0, out_corr, out_drops, out_pos, out_tag, out_shown};

endmodule

@@ bench/video_frame_presentation_queue_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_frame_presentation_queue_core_tb
// Self-checking bench for the frame presentation queue.
// ----------------------------------------------------------------------------
// Drives push, tick, clear and unused requests on the input stream and
// predicts every result with a queue model kept in a scoreboard. Starts with
// a short directed pass: clamps, empty queue, late drops, correction
// updates, queue-limit wrap. Then runs playback sessions under several
// register settings, extremes included, with random gaps on the input and
// random stalls on the output. Registers are written only with no request
// in flight.
// ----------------------------------------------------------------------------
module video_frame_presentation_queue_core_tb;

	import vfpq_pkg::*;

	localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
	localparam logic [30:0] MASTER_MAX   = 31'h7FFF_FFFF;
	localparam int          SETTLE_TICKS = 32;

	typedef struct packed {
		logic [10:0] corr;
		logic [7:0]  drops;
		logic [30:0] pos;
		logic [15:0] tag;
		logic        shown;
	} frame_result_t;

	typedef struct packed {
		logic [7:0]  limit;
		logic [15:0] late;
		logic [9:0]  tol;
		logic [9:0]  dead;
		logic [9:0]  maxc;
		logic [30:0] dur;
	} reg_set_t;

	// Queue model: frame store, correction, registers, and the results it owes.
	class presentation_scoreboard;
		logic signed [31:0] pts_mem [vfpq_pkg::DEF_QUEUE_DEPTH];
		logic [15:0]        tag_mem [vfpq_pkg::DEF_QUEUE_DEPTH];
		int                 head;
		int                 count;
		longint             corr;
		longint             queue_lim;
		longint             late_drop;
		longint             ahead_tol;
		longint             dead_zone;
		longint             max_corr;
		longint             duration;
		frame_result_t      pending_q [$];
		int                 mismatches;
		int                 checked;

		function new();
			head       = 0;
			count      = 0;
			corr       = 0;
			queue_lim  = longint'(RST_QUEUE_LIMIT);
			late_drop  = longint'(RST_LATE_DROP);
			ahead_tol  = longint'(RST_AHEAD_TOL);
			dead_zone  = longint'(RST_DEAD_ZONE);
			max_corr   = longint'(RST_MAX_CORR);
			duration   = longint'(RST_DURATION);
			mismatches = 0;
			checked    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
			case (idx)
				CFG_QUEUE_LIMIT: queue_lim = longint'(val[7:0]);
				CFG_LATE_DROP:   late_drop = longint'(val[15:0]);
				CFG_AHEAD_TOL:   ahead_tol = longint'(val[9:0]);
				CFG_DEAD_ZONE:   dead_zone = longint'(val[9:0]);
				CFG_MAX_CORR:    max_corr  = longint'(val[9:0]);
				CFG_DURATION:    duration  = longint'(val);
				default: ;
			endcase
		endfunction

		function int queue_cap();
			if (queue_lim < 1) return 1;
			if (queue_lim > vfpq_pkg::DEF_QUEUE_DEPTH) return vfpq_pkg::DEF_QUEUE_DEPTH;
			return int'(queue_lim);
		endfunction

		function void drop_head();
			if (count == 0) return;
			head = (head + 1) % vfpq_pkg::DEF_QUEUE_DEPTH;
			count--;
		endfunction

		function logic [30:0] clamp_pos(longint p);
			if (p < 0) p = 0;
			if (duration > 0 && p > duration) p = duration;
			return p[30:0];
		endfunction

		function void note_request(logic [1:0] op, logic play, logic [15:0] tag,
				logic signed [31:0] pts, logic [30:0] master);
			frame_result_t r;
			int            drops;
			int            slot;
			longint        master_v;
			longint        hp;
			longint        err;
			longint        mag;
			longint        blend;
			r        = '0;
			drops    = 0;
			master_v = longint'({1'b0, master});
			if (op == FUNC_PUSH) begin
				if (!play) begin
					r.shown = 1'b1;
					r.tag   = tag;
					r.pos   = clamp_pos(longint'(pts));
				end else begin
					// full: discard the oldest frame first
					if (count >= queue_cap()) begin
						drop_head();
						drops = 1;
					end
					slot          = (head + count) % vfpq_pkg::DEF_QUEUE_DEPTH;
					pts_mem[slot] = pts;
					tag_mem[slot] = tag;
					count++;
				end
			end else if (op == FUNC_TICK) begin
				if (!play) return;
				while (count > 0) begin
					hp = longint'(pts_mem[head]);
					if (count > queue_cap()) begin
						drop_head();
						drops++;
						continue;
					end
					// late frames go, but the last one stays
					if (hp + late_drop < master_v && count > 1) begin
						drop_head();
						drops++;
						continue;
					end
					if (hp <= master_v + corr + ahead_tol) begin
						err     = master_v - hp;
						mag     = (err < 0) ? -err : err;
						r.shown = 1'b1;
						r.tag   = tag_mem[head];
						r.pos   = clamp_pos(hp);
						drop_head();
						if (mag > dead_zone) begin
							blend = (corr * 3 + err) / 4;
							if (blend > max_corr) blend = max_corr;
							if (blend < -max_corr) blend = -max_corr;
							corr = blend;
						end
					end
					break;
				end
			end else begin
				if (op == FUNC_CLEAR) begin
					head  = 0;
					count = 0;
					corr  = 0;
				end
				return;
			end
			r.drops = (drops > 255) ? 8'd255 : drops[7:0];
			r.corr  = corr[10:0];
			pending_q.insert(pending_q.size(), r);
		endfunction

		task report(string what, logic [71:0] got, logic [71:0] want);
			mismatches++;
			$display("[%0t] result %0d, %s: got %0h, want %0h", $time, checked, what, got,
				want);
		endtask

		task check_result(logic [OUT_DATA_W-1:0] d);
			frame_result_t want;
			if (pending_q.size() == 0) begin
				report("unexpected result", d, '0);
				return;
			end
			want = pending_q[0];
			pending_q.delete(0);
			if (d[0] !== want.shown) report("shown", d[0], want.shown);
			if (d[16:1] !== want.tag) report("shown_tag", d[16:1], want.tag);
			if (d[47:17] !== want.pos) report("position_ms", d[47:17], want.pos);
			if (d[55:48] !== want.drops) report("dropped_count", d[55:48], want.drops);
			if (d[66:56] !== want.corr) report("correction_ms", d[66:56], want.corr);
			if (d[71:67] !== '0) report("padding", d[71:67], '0);
			checked++;
		endtask
	endclass

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser  = FUNC_PUSH;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = CFG_QUEUE_LIMIT;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	presentation_scoreboard sb;
	bit                     gaps_on  = 1'b1;
	bit                     stall_on = 1'b1;
	int                     rx_hold  = 0;

	video_frame_presentation_queue_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// Output backpressure: mostly short stalls, now and then a long one.
	always @(posedge clk) begin
		if (!stall_on) begin
			m_axis_tready <= 1'b1;
			rx_hold = 0;
		end else if (rx_hold > 0) begin
			rx_hold--;
		end else begin
			case ($urandom_range(0, 19))
				0: begin
					m_axis_tready <= 1'b0;
					rx_hold = $urandom_range(10, 40);
				end
				1, 2, 3, 4, 5, 6: begin
					m_axis_tready <= 1'b0;
					rx_hold = $urandom_range(0, 3);
				end
				default: begin
					m_axis_tready <= 1'b1;
					rx_hold = $urandom_range(0, 8);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	initial begin
		#24_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_request(logic [1:0] op, logic play, logic [15:0] tag,
			logic signed [31:0] pts, logic [30:0] master);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {master, pts, tag, play};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(op, play, tag, pts, master);
	endtask

	// Hold the input until every result is back, then let the block go quiet.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic program_regs(reg_set_t s);
		write_reg(CFG_QUEUE_LIMIT, 31'(s.limit));
		write_reg(CFG_LATE_DROP, 31'(s.late));
		write_reg(CFG_AHEAD_TOL, 31'(s.tol));
		write_reg(CFG_DEAD_ZONE, 31'(s.dead));
		write_reg(CFG_MAX_CORR, 31'(s.maxc));
		write_reg(CFG_DURATION, s.dur);
		cfg_valid <= 1'b0;
	endtask

	function automatic reg_set_t random_regs();
		reg_set_t s;
		s.limit = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 16)) :
			8'($urandom_range(0, 255));
		s.late  = 16'($urandom_range(0, 400));
		s.tol   = 10'($urandom_range(0, 60));
		s.dead  = 10'($urandom_range(0, 30));
		s.maxc  = 10'($urandom_range(0, 200));
		s.dur   = ($urandom_range(0, 1) == 0) ? 31'd0 : 31'($urandom);
		return s;
	endfunction

	task automatic directed_checks();
		reg_set_t s;
		// bypass: negative pts clamps to zero, top pts passes with no duration
		send_request(FUNC_PUSH, 1'b0, 16'hFFFF, 32'sh8000_0000, 31'd0);
		send_request(FUNC_PUSH, 1'b0, 16'h0000, 32'sh7FFF_FFFF, MASTER_MAX);
		// ignored: unused selector, paused tick
		send_request(FUNC_UNUSED, 1'b1, 16'hFFFF, 32'shFFFF_FFFF, MASTER_MAX);
		send_request(FUNC_TICK, 1'b0, 16'h1234, 32'sd0, MASTER_MAX);
		// tick on an empty queue
		send_request(FUNC_TICK, 1'b1, 16'h0000, 32'sd0, 31'd0);
		send_request(FUNC_PUSH, 1'b1, 16'd1, 32'sd1000, 31'd0);
		send_request(FUNC_PUSH, 1'b1, 16'd2, 32'sd1033, 31'd0);
		send_request(FUNC_PUSH, 1'b1, 16'd3, 32'sd1066, 31'd0);
		send_request(FUNC_TICK, 1'b1, 16'd0, 32'sd0, 31'd900);
		send_request(FUNC_TICK, 1'b1, 16'd0, 32'sd0, 31'd1000);
		// one late drop, last frame kept and shown, correction clamps
		send_request(FUNC_TICK, 1'b1, 16'd0, 32'sd0, 31'd1300);
		send_request(FUNC_PUSH, 1'b1, 16'd4, -32'sd100, 31'd0);
		send_request(FUNC_TICK, 1'b1, 16'd0, 32'sd0, 31'd0);
		send_request(FUNC_PUSH, 1'b1, 16'd5, 32'sd9000, 31'd0);
		send_request(FUNC_TICK, 1'b1, 16'd0, 32'sd0, 31'd8990);
		send_request(FUNC_PUSH, 1'b1, 16'd6, 32'sd20000, 31'd0);
		send_request(FUNC_TICK, 1'b1, 16'd0, 32'sd0, 31'd19900);
		send_request(FUNC_CLEAR, 1'b1, 16'd0, 32'sd0, 31'd0);
		send_request(FUNC_TICK, 1'b1, 16'd0, 32'sd0, 31'd100);
		settle();
		// zero limit acts as one; duration clamps the bypass position
		s = '{limit: 8'd0, late: RST_LATE_DROP, tol: RST_AHEAD_TOL, dead: RST_DEAD_ZONE,
			maxc: RST_MAX_CORR, dur: 31'd1000};
		program_regs(s);
		send_request(FUNC_PUSH, 1'b0, 16'hA5A5, 32'sd5000, 31'd0);
		send_request(FUNC_PUSH, 1'b1, 16'd7, 32'sd100, 31'd0);
		send_request(FUNC_PUSH, 1'b1, 16'd8, 32'sd200, 31'd0);
		send_request(FUNC_TICK, 1'b1, 16'd0, 32'sd0, MASTER_MAX);
	endtask

	// One playback session: frames pushed in pts order, ticks on an advancing
	// clock, with seeks, clears, bypass pushes and noise mixed in.
	task automatic play_session(int target, int tail);
		int          done_cnt;
		int          r;
		int          k;
		int          burst;
		int          step;
		int          next_pts;
		int          p;
		logic [30:0] clock_ms;
		done_cnt = 0;
		step     = $urandom_range(10, 50);
		case ($urandom_range(0, 3))
			0: clock_ms = 31'($urandom_range(0, 200));
			1: clock_ms = MASTER_MAX - 31'($urandom_range(0, 20000));
			default: clock_ms = 31'($urandom_range(0, 32'h3FFF_FFFF));
		endcase
		next_pts = int'({1'b0, clock_ms}) + int'($urandom_range(0, 60)) - 20;
		while (done_cnt < target) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				p = next_pts + int'($urandom_range(0, 4)) - 2;
				send_request(FUNC_PUSH, 1'b1, 16'($urandom), p, 31'($urandom));
				next_pts += step;
				done_cnt++;
			end else if (r < 38) begin
				burst = $urandom_range(2, 14);
				repeat (burst) begin
					send_request(FUNC_PUSH, 1'b1, 16'($urandom), next_pts, 31'($urandom));
					next_pts += step;
				end
				done_cnt += burst;
			end else if (r < 70) begin
				send_request(FUNC_TICK, 1'b1, 16'($urandom), $urandom, clock_ms);
				k = $urandom_range(0, 19);
				if (k == 0) clock_ms += 31'($urandom_range(150, 4000));
				else clock_ms += 31'($urandom_range(0, 2 * step));
				done_cnt++;
			end else if (r < 76) begin
				case ($urandom_range(0, 3))
					0: p = $urandom;
					1: p = -int'($urandom_range(0, 50));
					2: p = int'(sb.duration) + int'($urandom_range(0, 4)) - 2;
					default: p = next_pts;
				endcase
				send_request(FUNC_PUSH, 1'b0, 16'($urandom), p, 31'($urandom));
				done_cnt++;
			end else if (r < 80) begin
				send_request(FUNC_TICK, 1'b0, 16'($urandom), $urandom, 31'($urandom));
			end else if (r < 83) begin
				send_request(FUNC_CLEAR, 1'($urandom_range(0, 1)), 16'($urandom), $urandom,
					31'($urandom));
				done_cnt++;
			end else if (r < 85) begin
				send_request(FUNC_UNUSED, 1'($urandom_range(0, 1)), 16'($urandom), $urandom,
					31'($urandom));
			end else if (r < 90) begin
				send_request(FUNC_PUSH, 1'b1, 16'($urandom), $urandom, 31'($urandom));
				done_cnt++;
			end else if (r < 94) begin
				send_request(FUNC_TICK, 1'b1, 16'($urandom), $urandom, 31'($urandom));
				done_cnt++;
			end else if (r < 97) begin
				// seek: jump the clock and restart the pts run near it
				clock_ms = 31'($urandom);
				next_pts = int'({1'b0, clock_ms}) + int'($urandom_range(0, 100)) - 50;
			end else begin
				step = $urandom_range(10, 50);
			end
		end
		// leave frames behind for the next setting
		repeat (tail) begin
			send_request(FUNC_PUSH, 1'b1, 16'($urandom), next_pts, 31'($urandom));
			next_pts += step;
		end
	endtask

	initial begin
		reg_set_t regs;
		int       tail;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_checks();
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			tail = $urandom_range(0, 40);
			case (ph)
				0: regs = '{8'd8, 16'd120, 10'd5, 10'd8, 10'd40, 31'd0};
				1: regs = '{8'd0, 16'd0, 10'd0, 10'd0, 10'd0, 31'd1};
				2: begin
					regs = '{8'd255, 16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF, MASTER_MAX};
					tail = 135;
				end
				3: begin
					regs = '{8'd128, 16'd30, 10'd10, 10'd2, 10'h3FF, 31'd100000};
					tail = 140;
				end
				4: regs = '{8'd1, 16'd200, 10'd40, 10'd0, 10'd500, 31'd0};
				5: regs = '{8'd3, 16'd50, 10'd0, 10'd4, 10'd60, 31'd5000};
				default: regs = random_regs();
			endcase
			program_regs(regs);
			gaps_on  = (ph % 3) != 1;
			stall_on = (ph % 3) != 2;
			play_session(80, tail);
		end
		settle();
		if (sb.mismatches == 0 && sb.pending_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
